[design/rwst_pkg.sv]
// Shared types and constants for the register-write stream thinner.
`default_nettype none
package rwst_pkg;

   localparam int CODE_SPACE  = 256;
   localparam int MAP_ENTRIES = 128;
   localparam int CODE_AW     = $clog2(CODE_SPACE);
   localparam int MAP_AW      = $clog2(MAP_ENTRIES);

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Commands carried on the request side.
   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_PAIR = 2'd1;
   localparam logic [1:0] CMD_END  = 2'd2;

   // Result kinds.
   localparam logic KIND_PAIR  = 1'b0;
   localparam logic KIND_BLOCK = 1'b1;

   // Register indexes.
   localparam logic [1:0] REG_SHORT_CODE = 2'd0;
   localparam logic [1:0] REG_LONG_CODE  = 2'd1;
   localparam logic [1:0] REG_THRESHOLD  = 2'd2;
   localparam logic [1:0] REG_MIN_DELAY  = 2'd3;

   // Register classes that need a change above the threshold.
   localparam logic [3:0] CLASS_LEVEL = 4'hA;
   localparam logic [3:0] CLASS_FREQ  = 4'h4;

   localparam logic [7:0]  RST_SHORT_CODE = 8'd122;
   localparam logic [7:0]  RST_LONG_CODE  = 8'd123;
   localparam logic [7:0]  RST_THRESHOLD  = 8'd1;
   localparam logic [15:0] RST_MIN_DELAY  = 16'd23;

   typedef struct packed {
      logic [7:0]  short_code;
      logic [7:0]  long_code;
      logic [7:0]  threshold;
      logic [15:0] min_delay;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [7:0]        code;
      logic [7:0]        value;
      logic [MAP_AW-1:0] map_index;
      logic [7:0]        map_entry;
   } item_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  out_code;
      logic [7:0]  out_value;
      logic [15:0] block_delay;
      logic        long_flag;
   } result_type;

endpackage
`default_nettype wire

[design/rwst_csr.sv]
// Configuration registers behind the APB-style port.
`default_nettype none
module rwst_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [rwst_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [rwst_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [rwst_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready,
   output rwst_pkg::cfg_type                      cfg
);

   rwst_pkg::cfg_type cfg_ff;
   logic [1:0]        reg_idx;
   logic              wr_en;

   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_code <= rwst_pkg::RST_SHORT_CODE;
         cfg_ff.long_code  <= rwst_pkg::RST_LONG_CODE;
         cfg_ff.threshold  <= rwst_pkg::RST_THRESHOLD;
         cfg_ff.min_delay  <= rwst_pkg::RST_MIN_DELAY;
      end else if (wr_en) begin
         unique case (reg_idx)
            rwst_pkg::REG_SHORT_CODE: cfg_ff.short_code <= csr_pwdata[7:0];
            rwst_pkg::REG_LONG_CODE:  cfg_ff.long_code  <= csr_pwdata[7:0];
            rwst_pkg::REG_THRESHOLD:  cfg_ff.threshold  <= csr_pwdata[7:0];
            rwst_pkg::REG_MIN_DELAY:  cfg_ff.min_delay  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         rwst_pkg::REG_SHORT_CODE: csr_prdata = {24'd0, cfg_ff.short_code};
         rwst_pkg::REG_LONG_CODE:  csr_prdata = {24'd0, cfg_ff.long_code};
         rwst_pkg::REG_THRESHOLD:  csr_prdata = {24'd0, cfg_ff.threshold};
         rwst_pkg::REG_MIN_DELAY:  csr_prdata = {16'd0, cfg_ff.min_delay};
         default:                  csr_prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

[design/rwst_table.sv]
// Table memory with per-entry valid bits, registered read and write-to-read bypass.
`default_nettype none
module rwst_table #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [WIDTH-1:0] rd_ff;
   logic             rd_vld_ff;
   logic             fwd_ff;
   logic [WIDTH-1:0] fwd_data_ff;
   logic [AW-1:0]    unused_addr;

   assign unused_addr = wr_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_ff[unused_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff       <= storage_ff[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   // Entries never written read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
         fwd_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
            fwd_ff    <= wr_en && (wr_addr == rd_addr);
         end
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : (rd_vld_ff ? rd_ff : '0);

endmodule
`default_nettype wire

[design/rwst_core.sv]
// Per-item decision logic, delay accumulator and result register.
`default_nettype none
module rwst_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire rwst_pkg::cfg_type                 cfg,
   input  wire logic                              s1_valid,
   input  wire rwst_pkg::item_type                s1_item,
   input  wire logic [7:0]                        map_rd_data,
   input  wire logic [7:0]                        last_rd_data,
   input  wire logic                              rsp_ready,
   output logic                                   s1_advance,
   output logic                                   map_wr_en,
   output logic [rwst_pkg::MAP_AW-1:0]            map_wr_addr,
   output logic [7:0]                             map_wr_data,
   output logic                                   last_wr_en,
   output logic [rwst_pkg::CODE_AW-1:0]           last_wr_addr,
   output logic [7:0]                             last_wr_data,
   output logic                                   rsp_valid,
   output rwst_pkg::result_type                   rsp_result
);

   logic [15:0]          acc_ff;
   logic [15:0]          acc_in;
   logic                 rsp_valid_ff;
   rwst_pkg::result_type rsp_ff;
   rwst_pkg::result_type res_in;
   logic                 has_res_in;

   logic        is_delay;
   logic        is_long;
   logic [15:0] step;
   logic [15:0] sum;
   logic [15:0] close_delay;
   logic        close_long;
   logic [3:0]  cls;
   logic [7:0]  diff;
   logic        pass;

   assign s1_advance = s1_valid && (!rsp_valid_ff || rsp_ready);

   assign is_long  = (s1_item.code == cfg.long_code);
   assign is_delay = (s1_item.code == cfg.short_code) || is_long;
   assign step     = is_long ? {8'(s1_item.value + 8'd1), 8'h00}
                             : ({8'h00, s1_item.value} + 16'd1);
   assign sum      = acc_ff + step;
   assign close_long  = (sum[15:8] != 8'h00);
   assign close_delay = close_long ? (sum - 16'd256) : (sum - 16'd1);

   assign cls  = map_rd_data[7:4];
   assign diff = (s1_item.value >= last_rd_data) ? (s1_item.value - last_rd_data)
                                                 : (last_rd_data - s1_item.value);
   assign pass = ((cls == rwst_pkg::CLASS_LEVEL) || (cls == rwst_pkg::CLASS_FREQ))
               ? (diff > cfg.threshold) : (s1_item.value != last_rd_data);

   assign map_wr_addr  = s1_item.map_index;
   assign map_wr_data  = s1_item.map_entry;
   assign last_wr_addr = s1_item.code;
   assign last_wr_data = s1_item.value;

   always_comb begin
      acc_in     = acc_ff;
      has_res_in = 1'b0;
      res_in     = '0;
      map_wr_en  = 1'b0;
      last_wr_en = 1'b0;
      case (s1_item.command)
         rwst_pkg::CMD_LOAD: begin
            map_wr_en = s1_advance;
         end
         rwst_pkg::CMD_END: begin
            has_res_in         = 1'b1;
            res_in.kind        = rwst_pkg::KIND_BLOCK;
            res_in.block_delay = acc_ff;
            acc_in             = '0;
         end
         rwst_pkg::CMD_PAIR: begin
            if (is_delay) begin
               acc_in = sum;
               if (sum >= cfg.min_delay) begin
                  has_res_in         = 1'b1;
                  res_in.kind        = rwst_pkg::KIND_BLOCK;
                  res_in.block_delay = close_delay;
                  res_in.long_flag   = close_long;
                  acc_in             = '0;
               end
            end else if (pass) begin
               has_res_in       = 1'b1;
               res_in.kind      = rwst_pkg::KIND_PAIR;
               res_in.out_code  = s1_item.code;
               res_in.out_value = s1_item.value;
               last_wr_en       = s1_advance;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= has_res_in;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && has_res_in) begin
         rsp_ff <= res_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule
`default_nettype wire

[design/register_write_stream_thinner.sv]
// Top level of the register-write stream thinner.
`default_nettype none
// The thinner takes one item per clock cycle, with no bubbles, as long as results
// are taken when they are offered. The code map and last-value entries of an item
// are read at the edge that accepts it. The decision is made while the item sits
// in the input stage, and any result is loaded into the result register at the
// edge on which the item leaves that stage. The result register then holds and
// offers the result until the receiver takes it. An item that causes no result
// still passes through the input stage. A result that waits on the receiver keeps
// the next item in the input stage, and req_tready stays low until the result is taken.
// A register-write pair is passed on only if its value changed enough against
// the last value passed for the same code. Delay pairs are summed into a 16-bit
// accumulator and turned into a block-end item once the sum reaches min_delay.
// A load command writes one entry of the 128-entry code map, and an
// end-of-stream command flushes the raw accumulator as a block end. Both tables
// read as zero after reset without any clearing pass, so the block is ready in
// the first cycle after reset. Writes made by one item are forwarded to the
// next item, so back-to-back pairs on the same code see each other's updates.
// Configuration registers must only be written while the block is idle.
module register_write_stream_thinner (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // tdata: code[7:0], value[15:8], map_index[22:16], map_entry[30:23], zero pad
   input  wire logic [rwst_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: command[1:0]
   input  wire logic [1:0]                        req_tuser,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata: out_code[7:0], out_value[15:8], block_delay[31:16], long_flag[32], zero pad
   output logic      [rwst_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // tuser: kind[0]
   output logic                                   rsp_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [rwst_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [rwst_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [rwst_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);

   rwst_pkg::cfg_type    cfg;
   rwst_pkg::item_type   req_item;
   rwst_pkg::item_type   s1_item_ff;
   rwst_pkg::result_type rsp_result;
   logic                 s1_valid_ff;
   logic                 s1_advance;
   logic                 req_accept;

   logic                          map_wr_en;
   logic [rwst_pkg::MAP_AW-1:0]   map_wr_addr;
   logic [7:0]                    map_wr_data;
   logic [7:0]                    map_rd_data;
   logic                          last_wr_en;
   logic [rwst_pkg::CODE_AW-1:0]  last_wr_addr;
   logic [7:0]                    last_wr_data;
   logic [7:0]                    last_rd_data;

   // Unpack the incoming item.
   assign req_item.command   = req_tuser;
   assign req_item.code      = req_tdata[7:0];
   assign req_item.value     = req_tdata[15:8];
   assign req_item.map_index = req_tdata[22:16];
   assign req_item.map_entry = req_tdata[30:23];

   // The input stage frees up whenever its item moves on, even if that item
   // produces no result, so only a full result register that is not being taken stalls it.
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_item;
      end
   end

   rwst_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The code map is indexed by the low bits of the code.
   rwst_table #(
      .DEPTH (rwst_pkg::MAP_ENTRIES),
      .WIDTH (8)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (req_item.code[rwst_pkg::MAP_AW-1:0]),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_data (map_rd_data)
   );

   rwst_table #(
      .DEPTH (rwst_pkg::CODE_SPACE),
      .WIDTH (8)
   ) u_last (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (req_item.code),
      .wr_en   (last_wr_en),
      .wr_addr (last_wr_addr),
      .wr_data (last_wr_data),
      .rd_data (last_rd_data)
   );

   rwst_core u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .s1_valid     (s1_valid_ff),
      .s1_item      (s1_item_ff),
      .map_rd_data  (map_rd_data),
      .last_rd_data (last_rd_data),
      .rsp_ready    (rsp_tready),
      .s1_advance   (s1_advance),
      .map_wr_en    (map_wr_en),
      .map_wr_addr  (map_wr_addr),
      .map_wr_data  (map_wr_data),
      .last_wr_en   (last_wr_en),
      .last_wr_addr (last_wr_addr),
      .last_wr_data (last_wr_data),
      .rsp_valid    (rsp_tvalid),
      .rsp_result   (rsp_result)
   );

   // Pack the result item.
   assign rsp_tuser = rsp_result.kind;
   assign rsp_tdata = {7'd0, rsp_result.long_flag, rsp_result.block_delay,
                       rsp_result.out_value, rsp_result.out_code};

   // A passed pair never carries delay information.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == rwst_pkg::KIND_PAIR)) |-> (rsp_tdata[32:16] == '0))
      else $error("passed pair carries a delay or long flag");

   // The input stage only holds its item when the result register is full and stalled.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |-> (rsp_tvalid && !rsp_tready))
      else $error("input stage stalled without a blocked result");

   // A new result only shows up after an item left the input stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s1_advance))
      else $error("result appeared without an item moving on");

endmodule
`default_nettype wire
